// File: sv/u16u8_pkg.sv
// shared types, constants and the utf-8 byte formatter
// for the utf-16 to utf-8 encoder; no dependencies
package u16u8_pkg;

  localparam int unsigned UnitW = 16;
  localparam int unsigned CapW  = 16;
  localparam int unsigned CpW   = 21;
  localparam int unsigned PendW = 10;

  localparam logic [CapW-1:0] CapReset = 16'd512;
  localparam int unsigned QueueDepthDef = 2;

  localparam logic [UnitW-1:0] SurHighMin = 16'hD800;
  localparam logic [UnitW-1:0] SurHighMax = 16'hDBFF;
  localparam logic [UnitW-1:0] SurLowMin  = 16'hDC00;
  localparam logic [UnitW-1:0] SurLowMax  = 16'hDFFF;
  localparam logic [UnitW-1:0] Max1Byte   = 16'h007F;
  localparam logic [UnitW-1:0] Max2Byte   = 16'h07FF;
  localparam logic [10:0]      SuppOffset = 11'h040;  // 0x10000 >> 10
  localparam logic [5:0]       SurHighTag = 6'b110110;  // 0xD800 >> 10

  localparam logic [7:0] Lead2 = 8'hC0;
  localparam logic [7:0] Lead3 = 8'hE0;
  localparam logic [7:0] Lead4 = 8'hF0;
  localparam logic [7:0] ContB = 8'h80;

  typedef enum logic [1:0] {
    SLOT_NONE,
    SLOT_DATA,
    SLOT_MARK
  } slot_kind_e;

  // one character of a job: data bytes or an overflow marker
  typedef struct packed {
    slot_kind_e     kind;
    logic [CpW-1:0] cp;
    logic [2:0]     nbytes;
  } slot_t;

  // work for the back end caused by one accepted code unit
  typedef struct packed {
    slot_t a;
    slot_t b;
    logic  last;
    logic  quiet;
    logic  quiet_ovf;
  } job_t;

  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       last_of_item;
    logic       string_done;
    logic       overflow;
  } result_t;

  function automatic logic [7:0] cont_byte(logic [5:0] bits);
    return ContB | {2'b00, bits};
  endfunction

  function automatic logic [7:0] utf8_byte(logic [CpW-1:0] cp, logic [2:0] nbytes,
                                           logic [1:0] idx);
    logic [7:0] b;
    b = cont_byte(cp[5:0]);
    case (nbytes)
      3'd1: b = cp[7:0];
      3'd2: begin
        if (idx == 2'd0) b = Lead2 | {3'b000, cp[10:6]};
      end
      3'd3: begin
        case (idx)
          2'd0: b = Lead3 | {4'b0000, cp[15:12]};
          2'd1: b = cont_byte(cp[11:6]);
          default: b = cont_byte(cp[5:0]);
        endcase
      end
      3'd4: begin
        case (idx)
          2'd0: b = Lead4 | {5'b00000, cp[20:18]};
          2'd1: b = cont_byte(cp[17:12]);
          2'd2: b = cont_byte(cp[11:6]);
          default: b = cont_byte(cp[5:0]);
        endcase
      end
      default: b = cont_byte(cp[5:0]);
    endcase
    return b;
  endfunction

endpackage

// File: sv/u16u8_front.sv
// front end: accepts code units, pairs surrogates, checks the byte budget
// and builds at most one job per unit; depends on u16u8_pkg
module u16u8_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [u16u8_pkg::UnitW-1:0] code_unit_i,
  input  logic                        last_unit_i,
  input  logic [u16u8_pkg::CapW-1:0]  byte_capacity_i,
  output logic                        job_valid_o,
  input  logic                        job_ready_i,
  output u16u8_pkg::job_t             job_o
);
  import u16u8_pkg::*;

  typedef struct packed {
    slot_t           slot;
    logic            ovf;
    logic [CapW-1:0] used;
  } chk_t;

  function automatic chk_t check_char(logic en, logic [CpW-1:0] cp, logic [2:0] n,
                                      logic ovf, logic [CapW-1:0] used,
                                      logic [CapW-1:0] cap);
    chk_t r;
    logic [CapW+1:0] need_sum;
    r.slot.kind   = SLOT_NONE;
    r.slot.cp     = cp;
    r.slot.nbytes = n;
    r.ovf         = ovf;
    r.used        = used;
    need_sum = {2'b00, used} + {{(CapW-1){1'b0}}, n} + (CapW+2)'(1);
    if (en && !ovf) begin
      if (need_sum > {2'b00, cap}) begin
        r.slot.kind = SLOT_MARK;
        r.ovf       = 1'b1;
      end else begin
        r.slot.kind = SLOT_DATA;
        r.used      = used + {{(CapW-3){1'b0}}, n};
      end
    end
    return r;
  endfunction

  logic              pend_v_q, pend_v_d;
  logic [PendW-1:0]  pend_q, pend_d;
  logic [CapW-1:0]   used_q, used_d;
  logic              ovf_q, ovf_d;

  logic              is_high, is_low, pair, accept;
  logic              c0_en, c1_en;
  logic [CpW-1:0]    c0_cp, c1_cp;
  logic [2:0]        c0_n, c1_n;
  chk_t              chk0, chk1;
  job_t              job;

  always_comb begin
    is_high = (code_unit_i >= SurHighMin) && (code_unit_i <= SurHighMax);
    is_low  = (code_unit_i >= SurLowMin) && (code_unit_i <= SurLowMax);
    pair    = pend_v_q && is_low;

    if (pair) begin
      c0_en = 1'b1;
      c0_cp = {(11'({1'b0, pend_q}) + SuppOffset), code_unit_i[9:0]};
      c0_n  = 3'd4;
      c1_en = 1'b0;
    end else begin
      c0_en = pend_v_q;
      c0_cp = {5'b00000, SurHighTag, pend_q};
      c0_n  = 3'd3;
      c1_en = !(is_high && !last_unit_i);
    end
    c1_cp = {5'b00000, code_unit_i};
    if (code_unit_i <= Max1Byte) c1_n = 3'd1;
    else if (code_unit_i <= Max2Byte) c1_n = 3'd2;
    else c1_n = 3'd3;

    chk0 = check_char(c0_en, c0_cp, c0_n, ovf_q, used_q, byte_capacity_i);
    chk1 = check_char(c1_en, c1_cp, c1_n, chk0.ovf, chk0.used, byte_capacity_i);

    if (chk0.slot.kind == SLOT_NONE) begin
      job.a      = chk1.slot;
      job.b      = chk1.slot;
      job.b.kind = SLOT_NONE;
    end else begin
      job.a = chk0.slot;
      job.b = chk1.slot;
    end
    job.last      = last_unit_i;
    job.quiet     = last_unit_i && (job.a.kind == SLOT_NONE);
    job.quiet_ovf = chk1.ovf;
  end

  assign in_ready_o  = job_ready_i;
  assign accept      = in_valid_i && job_ready_i;
  assign job_valid_o = in_valid_i && ((job.a.kind != SLOT_NONE) || last_unit_i);
  assign job_o       = job;

  always_comb begin
    pend_v_d = pend_v_q;
    pend_d   = pend_q;
    used_d   = used_q;
    ovf_d    = ovf_q;
    if (accept) begin
      if (last_unit_i) begin
        pend_v_d = 1'b0;
        pend_d   = '0;
        used_d   = '0;
        ovf_d    = 1'b0;
      end else begin
        pend_v_d = !pair && is_high;
        pend_d   = code_unit_i[PendW-1:0];
        used_d   = chk1.used;
        ovf_d    = chk1.ovf;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      pend_q   <= '0;
      used_q   <= '0;
      ovf_q    <= 1'b0;
    end else begin
      pend_v_q <= pend_v_d;
      pend_q   <= pend_d;
      used_q   <= used_d;
      ovf_q    <= ovf_d;
    end
  end

endmodule

// File: sv/u16u8_queue.sv
// short job queue between front and back end, flop based
// depends on u16u8_pkg
module u16u8_queue #(
  parameter int unsigned Depth = u16u8_pkg::QueueDepthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  u16u8_pkg::job_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output u16u8_pkg::job_t pop_data_o
);
  import u16u8_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) cnt_d = cnt_q + CntW'(1);
    else if (!push && pop) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

// File: sv/u16u8_back.sv
// back end: walks the head job and emits one result per cycle while a job waits and
// the output is not stalled, into a registered output stage; depends on u16u8_pkg
module u16u8_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  input  u16u8_pkg::job_t    job_i,
  output logic               job_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output u16u8_pkg::result_t result_o
);
  import u16u8_pkg::*;

  logic       sel_q, sel_d;
  logic [1:0] idx_q, idx_d;
  logic       out_v_q, out_v_d;
  result_t    res_q, res;
  slot_t      cur;
  logic       slot_end, job_end, advance;

  always_comb begin
    cur      = sel_q ? job_i.b : job_i.a;
    res      = '0;
    slot_end = 1'b1;
    if (job_i.quiet) begin
      res.overflow = job_i.quiet_ovf;
    end else if (cur.kind == SLOT_DATA) begin
      res.data       = utf8_byte(cur.cp, cur.nbytes, idx_q);
      res.byte_valid = 1'b1;
      slot_end       = ({1'b0, idx_q} == (cur.nbytes - 3'd1));
    end else begin
      res.overflow = 1'b1;
    end
    job_end          = job_i.quiet || (slot_end && (sel_q || (job_i.b.kind == SLOT_NONE)));
    res.last_of_item = job_end;
    res.string_done  = job_end && job_i.last;

    advance   = job_valid_i && (!out_v_q || out_ready_i);
    job_pop_o = advance && job_end;

    sel_d   = sel_q;
    idx_d   = idx_q;
    out_v_d = out_v_q;
    if (advance) begin
      out_v_d = 1'b1;
      if (job_end) begin
        sel_d = 1'b0;
        idx_d = '0;
      end else if (slot_end) begin
        sel_d = 1'b1;
        idx_d = '0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end else if (out_ready_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q   <= 1'b0;
      idx_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      sel_q   <= sel_d;
      idx_q   <= idx_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) res_q <= res;
  end

  assign out_valid_o = out_v_q;
  assign result_o    = res_q;

endmodule

// File: sv/utf16_to_utf8_encoder.sv
// Converts a stream of UTF-16 code units into UTF-8 bytes with a per-string byte budget.
// The front end takes one code unit per cycle while the job queue has room, pairs
// surrogates and checks the budget, then queues a job; the back end emits one result per
// cycle from a registered output stage while the output is not stalled. A unit causes up
// to six results, and a held high surrogate causes none but still takes an input transfer.
// That output serializer sets the sustained rate; the job queue lets the input side run
// ahead by its depth. byte_capacity sits at APB address 0.
// A budget overflow gives one marker result (byte_valid low, overflow high) and then
// suppresses the rest of the string, whose last unit still gives a string_done result.
// Depends on u16u8_pkg, u16u8_front, u16u8_queue and u16u8_back.
module utf16_to_utf8_encoder #(
  parameter int unsigned QueueDepth = u16u8_pkg::QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // code_unit
  input  logic        s_axis_tlast,   // last_unit
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_byte
  output logic [2:0]  m_axis_tuser,   // byte_valid, last_of_item, overflow
  output logic        m_axis_tlast,   // string_done
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import u16u8_pkg::*;

  localparam logic RegCapacity = 1'b0;

  logic [CapW-1:0] cap_q;
  logic            cfg_write;
  logic            job_valid, job_ready, q_valid, q_pop;
  job_t            job, q_job;
  result_t         res;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == RegCapacity) ? {16'h0000, cap_q} : 32'h0000_0000;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (cfg_write && (paddr[2] == RegCapacity)) begin
      cap_q <= pwdata[CapW-1:0];
    end
  end

  u16u8_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .code_unit_i     (s_axis_tdata),
    .last_unit_i     (s_axis_tlast),
    .byte_capacity_i (cap_q),
    .job_valid_o     (job_valid),
    .job_ready_i     (job_ready),
    .job_o           (job)
  );

  u16u8_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (job_valid),
    .push_ready_o (job_ready),
    .push_data_i  (job),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_pop),
    .pop_data_o   (q_job)
  );

  u16u8_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (q_job),
    .job_pop_o   (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .result_o    (res)
  );

  assign m_axis_tdata = res.data;
  assign m_axis_tuser = {res.overflow, res.last_of_item, res.byte_valid};
  assign m_axis_tlast = res.string_done;

endmodule

// File: dv/utf16_to_utf8_encoder_test.sv
// self-checking testbench for utf16_to_utf8_encoder: directed table, then random strings
// checked against an in-bench utf-8 encoder model with its own budget and surrogate state
// depends on u16u8_pkg and the encoder rtl
`timescale 1ns / 100ps

module utf16_to_utf8_encoder_test;
  import u16u8_pkg::*;

  localparam int SETTLE       = 32;
  localparam int DRAIN_LIMIT  = 50000;
  localparam int PHASE_UNITS  = 75;
  localparam int NUM_PHASES   = 6;
  localparam int HOLD_CYCLES  = 400;
  localparam int REG_CAPACITY = 0;
  localparam int LIMIT_NS     = 1000000;
  localparam int NUM_ROWS     = 29;
  localparam logic [2:0] CAP_ADDR = 3'(REG_CAPACITY * 4);

  // fields from msb: data, valid, item_end, str_end, ovf
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       item_end;
    logic       str_end;
    logic       ovf;
  } utf8_out_t;

  typedef enum logic {ROW_UNIT, ROW_CAP} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [15:0] val;
    logic        fin;
    logic        typed;
    utf8_out_t   texp;
  } dir_row_t;

  localparam utf8_out_t NO_CHECK = '0;
  localparam utf8_out_t MARK_MID = {8'h00, 4'b0101};
  localparam utf8_out_t MARK_END = {8'h00, 4'b0111};

  localparam dir_row_t DIR_ROWS [NUM_ROWS] = '{
    '{ROW_UNIT, 16'h0041, 1'b1, 1'b1, {8'h41, 4'b1110}},
    '{ROW_UNIT, 16'h0000, 1'b0, 1'b1, {8'h00, 4'b1100}},
    '{ROW_UNIT, 16'h007F, 1'b1, 1'b1, {8'h7F, 4'b1110}},
    '{ROW_UNIT, 16'h0080, 1'b0, 1'b0, NO_CHECK},
    '{ROW_UNIT, 16'h07FF, 1'b0, 1'b0, NO_CHECK},
    '{ROW_UNIT, 16'h0800, 1'b0, 1'b0, NO_CHECK},
    '{ROW_UNIT, 16'hFFFF, 1'b1, 1'b0, NO_CHECK},
    '{ROW_UNIT, 16'hD83D, 1'b0, 1'b0, NO_CHECK},
    '{ROW_UNIT, 16'hDE00, 1'b1, 1'b0, NO_CHECK},
    '{ROW_UNIT, 16'hDBFF, 1'b0, 1'b0, NO_CHECK},
    '{ROW_UNIT, 16'hDFFF, 1'b0, 1'b0, NO_CHECK},
    '{ROW_UNIT, 16'hDC00, 1'b0, 1'b0, NO_CHECK},
    '{ROW_UNIT, 16'hD800, 1'b0, 1'b0, NO_CHECK},
    '{ROW_UNIT, 16'h0041, 1'b0, 1'b0, NO_CHECK},
    '{ROW_UNIT, 16'hDBFF, 1'b1, 1'b0, NO_CHECK},
    '{ROW_UNIT, 16'hD800, 1'b0, 1'b0, NO_CHECK},
    '{ROW_UNIT, 16'hD800, 1'b1, 1'b0, NO_CHECK},
    '{ROW_CAP,  16'h0004, 1'b0, 1'b0, NO_CHECK},
    '{ROW_UNIT, 16'h0041, 1'b0, 1'b1, {8'h41, 4'b1100}},
    '{ROW_UNIT, 16'h0800, 1'b0, 1'b1, MARK_MID},
    '{ROW_UNIT, 16'h0041, 1'b0, 1'b0, NO_CHECK},
    '{ROW_UNIT, 16'h0042, 1'b1, 1'b1, MARK_END},
    '{ROW_CAP,  16'h0002, 1'b0, 1'b0, NO_CHECK},
    '{ROW_UNIT, 16'h0041, 1'b0, 1'b1, {8'h41, 4'b1100}},
    '{ROW_UNIT, 16'h0042, 1'b1, 1'b1, MARK_END},
    '{ROW_CAP,  16'hFFFF, 1'b0, 1'b0, NO_CHECK},
    '{ROW_UNIT, 16'h0000, 1'b1, 1'b1, {8'h00, 4'b1110}},
    '{ROW_UNIT, 16'hD800, 1'b1, 1'b0, NO_CHECK},
    '{ROW_CAP,  16'h0200, 1'b0, 1'b0, NO_CHECK}
  };

  localparam logic [15:0] PHASE_CAP [NUM_PHASES] = '{
    16'd512, 16'd9, 16'd6, 16'd2, 16'd24, 16'hFFFF
  };

  logic        clk = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;  // code_unit
  logic        s_axis_tlast = 1'b0;  // last_unit
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;  // out_byte
  logic [2:0]  m_axis_tuser;  // byte_valid, last_of_item, overflow
  logic        m_axis_tlast;  // string_done
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // model state
  int unsigned m_cap;
  int unsigned m_pend_high;
  int unsigned m_used;
  bit          m_pend_v;
  bit          m_ovf;

  utf8_out_t   exp_q [$];
  utf8_out_t   mon_got, mon_exp;
  int          n_err = 0;
  int          n_in = 0;
  int          n_out = 0;
  int          n_str = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          hold_reqs = 0;

  utf16_to_utf8_encoder dut (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  task automatic report_mismatch(input string what, input utf8_out_t e, input utf8_out_t a);
    n_err++;
    if (n_err <= 10) begin
      $display("mismatch %s: expected data %h v%b i%b s%b o%b, got data %h v%b i%b s%b o%b",
               what, e.data, e.valid, e.item_end, e.str_end, e.ovf,
               a.data, a.valid, a.item_end, a.str_end, a.ovf);
    end
  endtask

  task automatic model_put(ref utf8_out_t res [$], input logic [7:0] b, input logic v);
    utf8_out_t r;
    r          = '0;
    r.data     = v ? b : 8'h00;
    r.valid    = v;
    r.ovf      = m_ovf;
    res.push_back(r);
  endtask

  task automatic model_encode(input int unsigned cp, ref utf8_out_t res [$]);
    int unsigned need;
    if (m_ovf) return;
    if (cp <= 32'h7F) need = 1;
    else if (cp <= 32'h7FF) need = 2;
    else if (cp <= 32'hFFFF) need = 3;
    else need = 4;
    if (m_used + need + 1 > m_cap) begin
      m_ovf = 1'b1;
      model_put(res, 8'h00, 1'b0);
      return;
    end
    case (need)
      1: begin
        model_put(res, 8'(cp), 1'b1);
      end
      2: begin
        model_put(res, 8'(32'hC0 | (cp >> 6)), 1'b1);
        model_put(res, 8'(32'h80 | (cp & 32'h3F)), 1'b1);
      end
      3: begin
        model_put(res, 8'(32'hE0 | (cp >> 12)), 1'b1);
        model_put(res, 8'(32'h80 | ((cp >> 6) & 32'h3F)), 1'b1);
        model_put(res, 8'(32'h80 | (cp & 32'h3F)), 1'b1);
      end
      default: begin
        model_put(res, 8'(32'hF0 | (cp >> 18)), 1'b1);
        model_put(res, 8'(32'h80 | ((cp >> 12) & 32'h3F)), 1'b1);
        model_put(res, 8'(32'h80 | ((cp >> 6) & 32'h3F)), 1'b1);
        model_put(res, 8'(32'h80 | (cp & 32'h3F)), 1'b1);
      end
    endcase
    m_used = (m_used + need) & 32'hFFFF;
  endtask

  task automatic model_step(input logic [15:0] unit, input logic fin, ref utf8_out_t res [$]);
    int unsigned u;
    int unsigned cp;
    bit          is_high;
    bit          is_low;
    utf8_out_t   last_r;
    u       = {16'h0000, unit};
    is_high = (u >= 32'hD800) && (u <= 32'hDBFF);
    is_low  = (u >= 32'hDC00) && (u <= 32'hDFFF);
    res.delete();
    if (m_pend_v && is_low) begin
      cp          = 32'h10000 + (m_pend_high << 10) + (u - 32'hDC00);
      m_pend_v    = 1'b0;
      m_pend_high = 0;
      model_encode(cp, res);
    end else begin
      if (m_pend_v) begin
        cp          = 32'hD800 + m_pend_high;
        m_pend_v    = 1'b0;
        m_pend_high = 0;
        model_encode(cp, res);
      end
      if (is_high && !fin) begin
        m_pend_high = (u - 32'hD800) & 32'h3FF;
        m_pend_v    = 1'b1;
      end else begin
        model_encode(u, res);
      end
    end
    if (fin && (res.size() == 0)) model_put(res, 8'h00, 1'b0);
    if (res.size() > 0) begin
      last_r          = res.pop_back();
      last_r.item_end = 1'b1;
      if (fin) last_r.str_end = 1'b1;
      res.push_back(last_r);
    end
    if (fin) begin
      m_pend_v    = 1'b0;
      m_pend_high = 0;
      m_used      = 0;
      m_ovf       = 1'b0;
    end
  endtask

  task automatic wait_drain();
    int guard;
    guard = 0;
    while ((exp_q.size() != 0) && (guard < DRAIN_LIMIT)) begin
      @(negedge clk);
      guard++;
    end
    if (exp_q.size() != 0) begin
      n_err++;
      $display("mismatch drain: %0d results still expected", exp_q.size());
    end
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic apb_write_cap(input logic [15:0] cap);
    wait_drain();
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = CAP_ADDR;
    pwdata  = {16'h0000, cap};
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    m_cap   = {16'h0000, cap};
  endtask

  task automatic send_unit(input logic [15:0] unit, input logic fin, input logic typed,
                           input utf8_out_t texp);
    utf8_out_t res [$];
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = unit;
    s_axis_tlast  = fin;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    model_step(unit, fin, res);
    n_in++;
    if (fin) n_str++;
    if (typed) begin
      exp_q.push_back(texp);
      if (res.size() != 1) report_mismatch("table row", texp, NO_CHECK);
      else if (res[0] !== texp) report_mismatch("table row", texp, res[0]);
    end else begin
      foreach (res[i]) exp_q.push_back(res[i]);
    end
    @(negedge clk);
    s_axis_tvalid = 1'b0;
  endtask

  function automatic logic [15:0] rand_unit();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 30) return 16'($urandom_range(32'h7F));
    else if (pick < 45) return 16'($urandom_range(32'h7FF, 32'h80));
    else if (pick < 65) return 16'($urandom_range(32'hFFFF, 32'h800));
    else if (pick < 85) return 16'($urandom_range(32'hDBFF, 32'hD800));
    else return 16'($urandom_range(32'hDFFF, 32'hDC00));
  endfunction

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin : limit_proc
    #(LIMIT_NS);
    $display("run did not finish in time");
    $display("status: fail");
    $finish;
  end

  // receiver ready pattern with a counted long hold
  initial begin : rx_proc
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      mon_got = {m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1], m_axis_tlast, m_axis_tuser[2]};
      n_out++;
      if (exp_q.size() == 0) begin
        report_mismatch("unexpected transfer", NO_CHECK, mon_got);
      end else begin
        mon_exp = exp_q.pop_front();
        if (mon_got !== mon_exp) report_mismatch("output", mon_exp, mon_got);
      end
    end
  end

  initial begin : stim_proc
    logic [15:0] u;
    logic        fin;
    logic        prev_high;
    m_cap       = {16'h0000, CapReset};
    m_pend_high = 0;
    m_pend_v    = 1'b0;
    m_used      = 0;
    m_ovf       = 1'b0;
    prev_high   = 1'b0;
    repeat (10) @(negedge clk);
    rst_ni = 1'b1;
    @(negedge clk);

    // register read after reset
    psel   = 1'b1;
    paddr  = CAP_ADDR;
    pwrite = 1'b0;
    @(posedge clk);
    if (prdata !== {16'h0000, CapReset}) begin
      n_err++;
      $display("mismatch register read: expected %h, got %h", {16'h0000, CapReset}, prdata);
    end
    @(negedge clk);
    psel = 1'b0;

    for (int r = 0; r < NUM_ROWS; r++) begin
      if (DIR_ROWS[r].kind == ROW_CAP) begin
        apb_write_cap(DIR_ROWS[r].val);
      end else begin
        send_unit(DIR_ROWS[r].val, DIR_ROWS[r].fin, DIR_ROWS[r].typed, DIR_ROWS[r].texp);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      apb_write_cap(PHASE_CAP[p]);
      if (p < 2) begin
        tx_idle_pct = 6;
        rx_idle_pct = 51;
      end else if (p < 4) begin
        tx_idle_pct = 51;
        rx_idle_pct = 6;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      for (int k = 0; k < PHASE_UNITS; k++) begin
        if (((p == 1) || (p == 4)) && (k == 10)) hold_reqs++;
        u = rand_unit();
        if (prev_high && ($urandom_range(99) < 60)) u = 16'($urandom_range(32'hDFFF, 32'hDC00));
        fin       = ($urandom_range(99) < 12) || (k == PHASE_UNITS - 1);
        prev_high = !fin && (u >= 16'hD800) && (u <= 16'hDBFF);
        send_unit(u, fin, 1'b0, NO_CHECK);
      end
    end

    wait_drain();

    $display("ran %0d code units in %0d strings: directed rows, then random text under six",
             n_in, n_str);
    $display("budgets with surrogates, overflow and stalls; %0d transfers checked, %0d errors",
             n_out, n_err);
    if (n_err == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// File: files.f
sv/u16u8_pkg.sv
sv/u16u8_front.sv
sv/u16u8_queue.sv
sv/u16u8_back.sv
sv/utf16_to_utf8_encoder.sv
dv/utf16_to_utf8_encoder_test.sv
